// ===== hdl/pfra_pkg.sv =====
// shared types and constants for the page frame run allocator
package pfra_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 1024;
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned FRAME_W        = 10;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [LEN_W-1:0] NUM_PAGES_RST = LEN_W'(1024);
  localparam logic [LEN_W-1:0] RESERVED_RST  = LEN_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    REQ_INIT     = 3'd0,
    REQ_KERNEL   = 3'd1,
    REQ_USER     = 3'd2,
    REQ_FREE_RUN = 3'd3,
    REQ_FREE_ONE = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    FS_FREE   = 2'd0,
    FS_KERNEL = 2'd1,
    FS_USER   = 2'd2,
    FS_FIXED  = 2'd3
  } frame_state_e;

  typedef enum logic [2:0] {
    CS_SWEEP,
    CS_IDLE,
    CS_SEARCH,
    CS_FREE_LEN,
    CS_WRITE
  } ctrl_state_e;

  typedef struct packed {
    frame_state_e     st;
    logic [LEN_W-1:0] len;
  } map_entry_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [LEN_W-1:0]   page_count;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [FRAME_W-1:0] start_frame;
    logic [LEN_W-1:0]   pages_in_use;
  } rsp_t;

endpackage

// ===== hdl/page_frame_run_allocator_top.sv =====
// page frame run allocator: configuration registers, sequencer and frame map
//
// channel   direction  signals                                  word
// request   in         start_i, busy_o, req_i                   req_t
// result    out        result_valid_o, result_o                 rsp_t
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i,   11-bit register value
//                      cfg_data_i
//
// one request at a time; the result strobe comes the cycle after the work ends
// init: a sweep over the whole map, one map entry written per cycle
// kernel or user alloc: a first-fit search on the map read port, then one write
// per granted frame; free run: a read of the run length, then one write per run frame
// free one frame and unknown requests: finished in the cycle that accepts them
// after reset the map is cleared with busy_o high;
// results cannot be stalled, config writes are taken every cycle
module page_frame_run_allocator_top import pfra_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 result_valid_o,
  output rsp_t                 result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  logic [LEN_W-1:0] num_pages_q, num_pages_d;
  logic [LEN_W-1:0] reserved_q, reserved_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  map_entry_t    wdata, rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    num_pages_d = num_pages_q;
    reserved_d  = reserved_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_PAGES: num_pages_d = cfg_data_i;
        CFG_RESERVED:  reserved_d  = cfg_data_i;
        default:       num_pages_d = num_pages_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pages_q <= NUM_PAGES_RST;
      reserved_q  <= RESERVED_RST;
    end else begin
      num_pages_q <= num_pages_d;
      reserved_q  <= reserved_d;
    end
  end

  pfra_ctrl #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .num_pages_i    (num_pages_q),
    .reserved_i     (reserved_q),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  pfra_map_mem #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== hdl/pfra_map_mem.sv =====
// frame map memory: one write port, one read port with registered data
module pfra_map_mem import pfra_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] waddr_i,
  input  map_entry_t                                      wdata_i,
  input  logic                                            re_i,
  input  logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] raddr_i,
  output map_entry_t                                      rdata_o
);

  map_entry_t mem_q [NUM_FRAMES];
  map_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pfra_ctrl.sv =====
// request sequencer: sweeps, first-fit search, run writes and the in-use count
module pfra_ctrl import pfra_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  req_t                                            req_i,
  output logic                                            busy_o,
  output logic                                            result_valid_o,
  output rsp_t                                            result_o,
  input  logic [LEN_W-1:0]                                num_pages_i,
  input  logic [LEN_W-1:0]                                reserved_i,
  output logic                                            we_o,
  output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] waddr_o,
  output map_entry_t                                      wdata_o,
  output logic                                            re_o,
  output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] raddr_o,
  input  map_entry_t                                      rdata_i
);

  localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned XW = (CW > 12) ? CW : 12;
  localparam logic [XW-1:0] NF  = XW'(NUM_FRAMES);
  localparam logic [XW-1:0] CAP = (NUM_FRAMES < 2047) ? XW'(NUM_FRAMES) : XW'(2047);

  ctrl_state_e state_q, state_d;
  logic [XW-1:0] iss_q, iss_d;
  logic [XW-1:0] chk_q, chk_d;
  logic          pend_q, pend_d;
  logic [XW-1:0] run_q, run_d;
  logic [XW-1:0] len_q, len_d;
  logic [XW-1:0] base_q, base_d;
  logic [XW-1:0] wcnt_q, wcnt_d;
  logic [XW-1:0] nf_q, nf_d;
  logic [XW-1:0] rv_q, rv_d;
  frame_state_e  wst_q, wst_d;
  logic [LEN_W-1:0] used_q, used_d;
  logic          init_sweep_q, init_sweep_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic [XW-1:0] frm_x, cnt_x, np_x, rsv_x, nf_now, rv_now;
  logic [XW-1:0] run_n, s_found, len_rd, room, walk_len, n_sel, used_x;
  logic [XW-1:0] add_res, sub_res;
  logic [XW-1:0] wr_addr;
  logic          accept, frm_ok, hit, miss, wr_last, sweep_last, issue;

  assign frm_x  = XW'(req_i.frame);
  assign cnt_x  = XW'(req_i.page_count);
  assign np_x   = XW'(num_pages_i);
  assign rsv_x  = XW'(reserved_i);
  assign nf_now = (np_x < NF) ? np_x : NF;
  assign rv_now = (rsv_x < nf_now) ? rsv_x : nf_now;
  assign frm_ok = frm_x < NF;
  assign accept = start_i && (state_q == CS_IDLE);

  // search pipeline: data for frame chk_q arrives in the cycle after its read
  assign run_n      = (rdata_i.st == FS_FREE) ? run_q + XW'(1) : '0;
  assign hit        = pend_q && (run_n == len_q);
  assign s_found    = chk_q + XW'(1) - len_q;
  assign miss       = pend_q && !hit && (chk_q == nf_q - XW'(1));
  assign issue      = iss_q < nf_q;

  // run free stops at the end of the map
  assign len_rd     = XW'(rdata_i.len);
  assign room       = NF - base_q;
  assign walk_len   = (len_rd < room) ? len_rd : room;

  assign wr_last    = wcnt_q == len_q - XW'(1);
  assign sweep_last = iss_q == NF - XW'(1);
  assign wr_addr    = base_q + wcnt_q;

  // saturating in-use count
  assign used_x  = XW'(used_q);
  assign n_sel   = (state_q == CS_IDLE) ? XW'(1) : len_q;
  assign add_res = (n_sel >= CAP - used_x) ? CAP : used_x + n_sel;
  assign sub_res = (n_sel >= used_x) ? '0 : used_x - n_sel;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_SWEEP: begin
        if (sweep_last) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_INIT:     state_d = CS_SWEEP;
            REQ_KERNEL: begin
              if (cnt_x != '0 && nf_now != '0) state_d = CS_SEARCH;
            end
            REQ_USER: begin
              if (nf_now != '0) state_d = CS_SEARCH;
            end
            REQ_FREE_RUN: begin
              if (frm_ok) state_d = CS_FREE_LEN;
            end
            default:      state_d = CS_IDLE;
          endcase
        end
      end
      CS_SEARCH: begin
        if (hit) begin
          state_d = (s_found != '0) ? CS_WRITE : CS_IDLE;
        end else if (miss) begin
          state_d = CS_IDLE;
        end
      end
      CS_FREE_LEN: begin
        state_d = (walk_len != '0) ? CS_WRITE : CS_IDLE;
      end
      CS_WRITE: begin
        if (wr_last) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    iss_d        = iss_q;
    chk_d        = chk_q;
    pend_d       = pend_q;
    run_d        = run_q;
    len_d        = len_q;
    base_d       = base_q;
    wcnt_d       = wcnt_q;
    nf_d         = nf_q;
    rv_d         = rv_q;
    wst_d        = wst_q;
    used_d       = used_q;
    init_sweep_d = init_sweep_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    we_o         = 1'b0;
    waddr_o      = iss_q[AW-1:0];
    wdata_o.st   = FS_FREE;
    wdata_o.len  = '0;
    re_o         = 1'b0;
    raddr_o      = iss_q[AW-1:0];

    case (state_q)
      CS_SWEEP: begin
        we_o    = 1'b1;
        waddr_o = iss_q[AW-1:0];
        if (iss_q < rv_q) begin
          wdata_o.st  = FS_FIXED;
          wdata_o.len = LEN_W'(1);
        end
        iss_d = iss_q + XW'(1);
        if (sweep_last) begin
          iss_d        = '0;
          init_sweep_d = 1'b0;
          if (init_sweep_q) begin
            done_d            = 1'b1;
            rsp_d.status      = 1'b0;
            rsp_d.start_frame = '0;
          end
        end
      end
      CS_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_INIT: begin
              rv_d         = rv_now;
              iss_d        = '0;
              init_sweep_d = 1'b1;
              used_d       = '0;
            end
            REQ_KERNEL, REQ_USER: begin
              len_d  = (req_i.req_type == REQ_KERNEL) ? cnt_x : XW'(1);
              wst_d  = (req_i.req_type == REQ_KERNEL) ? FS_KERNEL : FS_USER;
              nf_d   = nf_now;
              iss_d  = '0;
              chk_d  = '0;
              pend_d = 1'b0;
              run_d  = '0;
              if (nf_now == '0 || (req_i.req_type == REQ_KERNEL && cnt_x == '0)) begin
                done_d            = 1'b1;
                rsp_d.status      = 1'b1;
                rsp_d.start_frame = '0;
              end
            end
            REQ_FREE_RUN: begin
              base_d = frm_x;
              wst_d  = FS_FREE;
              if (frm_ok) begin
                re_o    = 1'b1;
                raddr_o = frm_x[AW-1:0];
              end else begin
                done_d            = 1'b1;
                rsp_d.status      = 1'b0;
                rsp_d.start_frame = '0;
              end
            end
            REQ_FREE_ONE: begin
              if (frm_ok) begin
                we_o    = 1'b1;
                waddr_o = frm_x[AW-1:0];
                used_d  = sub_res[LEN_W-1:0];
              end
              done_d            = 1'b1;
              rsp_d.status      = 1'b0;
              rsp_d.start_frame = '0;
            end
            default: begin
              done_d            = 1'b1;
              rsp_d.status      = 1'b0;
              rsp_d.start_frame = '0;
            end
          endcase
        end
      end
      CS_SEARCH: begin
        re_o    = issue;
        raddr_o = iss_q[AW-1:0];
        if (issue) iss_d = iss_q + XW'(1);
        pend_d  = issue;
        if (pend_q) begin
          run_d = run_n;
          chk_d = chk_q + XW'(1);
        end
        if (hit) begin
          base_d = s_found;
          wcnt_d = '0;
          // a run that would start at frame zero is refused
          if (s_found == '0) begin
            done_d            = 1'b1;
            rsp_d.status      = 1'b1;
            rsp_d.start_frame = '0;
          end
        end else if (miss) begin
          done_d            = 1'b1;
          rsp_d.status      = 1'b1;
          rsp_d.start_frame = '0;
        end
      end
      CS_FREE_LEN: begin
        len_d  = walk_len;
        wcnt_d = '0;
        if (walk_len == '0) begin
          done_d            = 1'b1;
          rsp_d.status      = 1'b0;
          rsp_d.start_frame = '0;
        end
      end
      CS_WRITE: begin
        we_o       = 1'b1;
        waddr_o    = wr_addr[AW-1:0];
        wdata_o.st = wst_q;
        // length lives at the first frame; free frames always hold zero
        if (wcnt_q == '0 && wst_q != FS_FREE) wdata_o.len = len_q[LEN_W-1:0];
        wcnt_d = wcnt_q + XW'(1);
        if (wr_last) begin
          done_d       = 1'b1;
          rsp_d.status = 1'b0;
          if (wst_q == FS_FREE) begin
            used_d            = sub_res[LEN_W-1:0];
            rsp_d.start_frame = '0;
          end else begin
            used_d            = add_res[LEN_W-1:0];
            rsp_d.start_frame = base_q[FRAME_W-1:0];
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    if (done_d) rsp_d.pages_in_use = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_SWEEP;
      iss_q        <= '0;
      chk_q        <= '0;
      pend_q       <= 1'b0;
      run_q        <= '0;
      wcnt_q       <= '0;
      nf_q         <= '0;
      rv_q         <= '0;
      used_q       <= '0;
      init_sweep_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      iss_q        <= iss_d;
      chk_q        <= chk_d;
      pend_q       <= pend_d;
      run_q        <= run_d;
      wcnt_q       <= wcnt_d;
      nf_q         <= nf_d;
      rv_q         <= rv_d;
      used_q       <= used_d;
      init_sweep_q <= init_sweep_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    base_q <= base_d;
    wst_q  <= wst_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o         = state_q != CS_IDLE;
  assign result_valid_o = done_q;
  assign result_o       = rsp_q;

endmodule
